// ===== rtl/spsa_pkg.sv =====
`timescale 1ns / 1ps
package spsa_pkg;

  localparam int COORD_W  = 24;
  localparam int RADIUS_W = 23;
  localparam int IDX_W    = 5;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [1:0] REG_SNAP_RADIUS = 2'd0;
  localparam logic [1:0] REG_SNAP_EN     = 2'd1;
  localparam logic [1:0] REG_HORIZ_EN    = 2'd2;
  localparam logic [1:0] REG_VERT_EN     = 2'd3;

  typedef enum logic [2:0] {
    KIND_HORIZ   = 3'd0,
    KIND_VERT    = 3'd1,
    KIND_ADDED   = 3'd2,
    KIND_SNAPPED = 3'd3,
    KIND_FULL    = 3'd4,
    KIND_CLEARED = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT,
    ST_CLR
  } state_e;

  typedef struct packed {
    logic             start;
    logic             clear_count;
    logic             issue;
    logic [IDX_W-1:0] idx;
    logic             append;
    logic             emit;
    kind_e            emit_kind;
    logic [IDX_W-1:0] emit_point;
    logic [IDX_W-1:0] emit_other;
    logic             emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] count;
    logic             full;
    logic             pipe_busy;
    logic             snap_found;
    logic [IDX_W-1:0] snap_idx;
    logic [IDX_W-1:0] new_idx;
    logic             h_bit;
    logic             v_bit;
    logic             out_free;
  } dp_status_t;

endpackage

// ===== rtl/spsa_ctrl.sv =====
`timescale 1ns / 1ps
module spsa_ctrl import spsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_op_i,
  output logic       in_ready_o,
  input  logic       snap_en_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             hdone_q, hdone_d;
  logic             accept;
  logic             issue;
  logic             at_new;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign issue      = (idx_q < status_i.count);
  assign at_new     = (idx_q == status_i.new_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      hdone_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      hdone_q <= hdone_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_op_i == OP_CLEAR) ? ST_CLR : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue && !status_i.pipe_busy) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if ((snap_en_i && status_i.snap_found) || status_i.full) begin
          if (status_i.out_free) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (at_new && status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLR: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o   = '0;
    idx_d   = idx_q;
    hdone_d = hdone_q;
    cmd_o.idx = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_op_i == OP_CLEAR) begin
            cmd_o.clear_count = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            idx_d       = '0;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          cmd_o.issue = 1'b1;
          idx_d       = idx_q + 1'b1;
        end
      end
      ST_DECIDE: begin
        if (snap_en_i && status_i.snap_found) begin
          cmd_o.emit       = status_i.out_free;
          cmd_o.emit_kind  = KIND_SNAPPED;
          cmd_o.emit_point = status_i.snap_idx;
          cmd_o.emit_last  = 1'b1;
        end else if (status_i.full) begin
          cmd_o.emit      = status_i.out_free;
          cmd_o.emit_kind = KIND_FULL;
          cmd_o.emit_last = 1'b1;
        end else begin
          cmd_o.append = 1'b1;
          idx_d        = '0;
          hdone_d      = 1'b0;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_point = status_i.new_idx;
        cmd_o.emit_other = idx_q;
        if (at_new) begin
          cmd_o.emit       = status_i.out_free;
          cmd_o.emit_kind  = KIND_ADDED;
          cmd_o.emit_other = '0;
          cmd_o.emit_last  = 1'b1;
        end else if (status_i.h_bit && !hdone_q) begin
          cmd_o.emit_kind = KIND_HORIZ;
          if (status_i.out_free) begin
            cmd_o.emit = 1'b1;
            if (status_i.v_bit) begin
              hdone_d = 1'b1;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
        end else if (status_i.v_bit) begin
          cmd_o.emit_kind = KIND_VERT;
          if (status_i.out_free) begin
            cmd_o.emit = 1'b1;
            idx_d      = idx_q + 1'b1;
            hdone_d    = 1'b0;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          hdone_d = 1'b0;
        end
      end
      ST_CLR: begin
        cmd_o.emit      = status_i.out_free;
        cmd_o.emit_kind = KIND_CLEARED;
        cmd_o.emit_last = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/spsa_dp.sv =====
`timescale 1ns / 1ps
module spsa_dp import spsa_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  input  logic [COORD_W-1:0]  in_x_i,
  input  logic [COORD_W-1:0]  in_y_i,
  input  logic [RADIUS_W-1:0] radius_i,
  input  logic                horiz_en_i,
  input  logic                vert_en_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output kind_e               out_kind_o,
  output logic [IDX_W-1:0]    out_point_o,
  output logic [IDX_W-1:0]    out_other_o,
  output logic                out_last_o
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);
  localparam int SQ_W = 2 * COORD_W;

  logic [COORD_W-1:0] sx_q [MAX_POINTS];
  logic [COORD_W-1:0] sy_q [MAX_POINTS];
  logic [MAX_POINTS-1:0] hbits_q;
  logic [MAX_POINTS-1:0] vbits_q;

  logic [CW-1:0]      count_q;
  logic [IDX_W-1:0]   new_idx_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [2*RADIUS_W-1:0] r2_q;

  logic               v1_q, v2_q;
  logic [AW-1:0]      i1_q, i2_q;
  logic [COORD_W-1:0] ax1_q, ay1_q, ax2_q, ay2_q;
  logic [SQ_W-1:0]    sqx_q, sqy_q;

  logic               snap_found_q;
  logic [IDX_W-1:0]   snap_idx_q;

  logic               out_valid_q;
  kind_e              out_kind_q;
  logic [IDX_W-1:0]   out_point_q, out_other_q;
  logic               out_last_q;

  logic [AW-1:0]      ra;
  logic [COORD_W:0]   dx_w, dy_w, ndx_w, ndy_w;
  logic [COORD_W-1:0] ax_w, ay_w;
  logic [SQ_W:0]      sum_w, r2_w;
  logic [COORD_W-1:0] r_w;
  logic               near_w, far_w;

  assign ra    = cmd_i.idx[AW-1:0];
  assign dx_w  = {x_q[COORD_W-1], x_q} - {sx_q[ra][COORD_W-1], sx_q[ra]};
  assign dy_w  = {y_q[COORD_W-1], y_q} - {sy_q[ra][COORD_W-1], sy_q[ra]};
  assign ndx_w = ~dx_w + 1'b1;
  assign ndy_w = ~dy_w + 1'b1;
  assign ax_w  = dx_w[COORD_W] ? ndx_w[COORD_W-1:0] : dx_w[COORD_W-1:0];
  assign ay_w  = dy_w[COORD_W] ? ndy_w[COORD_W-1:0] : dy_w[COORD_W-1:0];

  assign sum_w  = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign r2_w   = (SQ_W + 1)'(r2_q);
  assign r_w    = {1'b0, radius_i};
  assign near_w = sum_w < r2_w;
  assign far_w  = sum_w > r2_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      snap_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.clear_count) begin
        count_q <= '0;
      end else if (cmd_i.append) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.start) begin
        snap_found_q <= 1'b0;
      end else if (v2_q && near_w) begin
        snap_found_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q <= radius_i * radius_i;
    if (cmd_i.start) begin
      x_q <= in_x_i;
      y_q <= in_y_i;
    end
    if (cmd_i.append) begin
      sx_q[count_q[AW-1:0]] <= x_q;
      sy_q[count_q[AW-1:0]] <= y_q;
      new_idx_q <= IDX_W'(count_q);
    end
    i1_q  <= ra;
    ax1_q <= ax_w;
    ay1_q <= ay_w;
    i2_q  <= i1_q;
    ax2_q <= ax1_q;
    ay2_q <= ay1_q;
    sqx_q <= ax1_q * ax1_q;
    sqy_q <= ay1_q * ay1_q;
    if (v2_q) begin
      hbits_q[i2_q] <= far_w && horiz_en_i && (ay2_q < r_w);
      vbits_q[i2_q] <= far_w && vert_en_i && (ax2_q < r_w);
      if (!snap_found_q && near_w) begin
        snap_idx_q <= IDX_W'(i2_q);
      end
    end
    if (cmd_i.emit) begin
      out_kind_q  <= cmd_i.emit_kind;
      out_point_q <= cmd_i.emit_point;
      out_other_q <= cmd_i.emit_other;
      out_last_q  <= cmd_i.emit_last;
    end
  end

  always_comb begin
    status_o            = '0;
    status_o.count      = IDX_W'(count_q);
    status_o.full       = (count_q == MAX_CNT);
    status_o.pipe_busy  = v1_q || v2_q;
    status_o.snap_found = snap_found_q;
    status_o.snap_idx   = snap_idx_q;
    status_o.new_idx    = new_idx_q;
    status_o.h_bit      = hbits_q[ra];
    status_o.v_bit      = vbits_q[ra];
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_point_o = out_point_q;
  assign out_other_o = out_other_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/sketch_point_snap_align.sv =====
`timescale 1ns / 1ps
// Sketch point store with coincidence snapping and alignment inference. Each input beat
// either clears the store or adds a point; result beats come out in order, with tlast on the
// final one of each item. An add with n stored points first walks all n points through a
// two-stage squared-distance pipeline at one point per cycle, then decides. A snapped or
// store-full add ends there; an appended point then walks the stored points once more at
// one point per cycle, giving a point aligned both ways its horizontal beat and then its
// vertical one, holding any beat while the output is stalled, and closes with the added
// beat. A new beat is taken as soon as the last result of the previous one sits in the
// output register.
module sketch_point_snap_align import spsa_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // coord_x [23:0], coord_y [47:24]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // point_index [4:0], other_index [9:5], zeros above
  output logic [2:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [RADIUS_W-1:0] radius_q;
  logic                snap_en_q;
  logic                horiz_en_q;
  logic                vert_en_q;
  logic                cfg_wr;
  dp_cmd_t             cmd;
  dp_status_t          status;
  kind_e               out_kind;
  logic [IDX_W-1:0]    out_point;
  logic [IDX_W-1:0]    out_other;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RADIUS_W'(4096);
      snap_en_q  <= 1'b1;
      horiz_en_q <= 1'b1;
      vert_en_q  <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SNAP_RADIUS: radius_q   <= pwdata[RADIUS_W-1:0];
        REG_SNAP_EN:     snap_en_q  <= pwdata[0];
        REG_HORIZ_EN:    horiz_en_q <= pwdata[0];
        REG_VERT_EN:     vert_en_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SNAP_RADIUS: prdata = 32'(radius_q);
      REG_SNAP_EN:     prdata = 32'(snap_en_q);
      REG_HORIZ_EN:    prdata = 32'(horiz_en_q);
      REG_VERT_EN:     prdata = 32'(vert_en_q);
      default:         prdata = '0;
    endcase
  end

  spsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .snap_en_i  (snap_en_q),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spsa_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_x_i      (s_axis_tdata[23:0]),
    .in_y_i      (s_axis_tdata[47:24]),
    .radius_i    (radius_q),
    .horiz_en_i  (horiz_en_q),
    .vert_en_i   (vert_en_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (out_kind),
    .out_point_o (out_point),
    .out_other_o (out_other),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {6'b0, out_other, out_point};

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
import spsa_pkg::*;

typedef struct {
  kind_e      kind;
  logic [4:0] point_idx;
  logic [4:0] other_idx;
  logic       last;
} align_beat_t;

class snap_align_scoreboard;
  localparam int DEPTH = 16;

  logic signed [23:0] px[DEPTH];
  logic signed [23:0] py[DEPTH];
  int unsigned        count;
  logic [22:0]        radius;
  logic               snap_en;
  logic               horiz_en;
  logic               vert_en;
  align_beat_t        expected_beats[$];
  int unsigned        mismatches;

  function new();
    count      = 0;
    radius     = 23'd4096;
    snap_en    = 1'b1;
    horiz_en   = 1'b1;
    vert_en    = 1'b1;
    mismatches = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] value);
    case (idx)
      REG_SNAP_RADIUS: radius = value[22:0];
      REG_SNAP_EN:     snap_en = value[0];
      REG_HORIZ_EN:    horiz_en = value[0];
      REG_VERT_EN:     vert_en = value[0];
      default: ;
    endcase
  endfunction

  function void push_beat(kind_e kind, int unsigned pi, int unsigned oi, logic last);
    align_beat_t b;
    b.kind      = kind;
    b.point_idx = pi[4:0];
    b.other_idx = oi[4:0];
    b.last      = last;
    expected_beats.push_back(b);
  endfunction

  function longint mag(longint d);
    return (d < 0) ? -d : d;
  endfunction

  function void note_item(logic op, logic signed [23:0] x, logic signed [23:0] y);
    longint ax, ay, r, r2;
    int unsigned i, cnt;
    r   = longint'(radius);
    r2  = r * r;
    cnt = count;
    if (op == OP_CLEAR) begin
      count = 0;
      push_beat(KIND_CLEARED, 0, 0, 1'b1);
      return;
    end
    if (snap_en) begin
      for (i = 0; i < cnt; i++) begin
        ax = mag(longint'(x) - longint'(px[i]));
        ay = mag(longint'(y) - longint'(py[i]));
        if (ax * ax + ay * ay < r2) begin
          push_beat(KIND_SNAPPED, i, 0, 1'b1);
          return;
        end
      end
    end
    if (cnt >= DEPTH) begin
      push_beat(KIND_FULL, 0, 0, 1'b1);
      return;
    end
    px[cnt] = x;
    py[cnt] = y;
    count   = cnt + 1;
    for (i = 0; i < cnt; i++) begin
      ax = mag(longint'(x) - longint'(px[i]));
      ay = mag(longint'(y) - longint'(py[i]));
      if (ax * ax + ay * ay > r2) begin
        if (horiz_en && ay < r) push_beat(KIND_HORIZ, cnt, i, 1'b0);
        if (vert_en && ax < r) push_beat(KIND_VERT, cnt, i, 1'b0);
      end
    end
    push_beat(KIND_ADDED, cnt, 0, 1'b1);
  endfunction

  function void check_beat(logic [2:0] kind, logic [4:0] pi, logic [4:0] oi, logic last);
    align_beat_t exp;
    if (expected_beats.size() == 0) begin
      $error("result beat with nothing pending: kind %0d, point %0d", kind, pi);
      mismatches++;
      return;
    end
    exp = expected_beats.pop_front();
    if (exp.kind !== kind) begin
      $error("kind: expected %0d, actual %0d", exp.kind, kind);
      mismatches++;
    end
    if (exp.point_idx !== pi) begin
      $error("point_index: expected %0d, actual %0d", exp.point_idx, pi);
      mismatches++;
    end
    if (exp.other_idx !== oi) begin
      $error("other_index: expected %0d, actual %0d", exp.other_idx, oi);
      mismatches++;
    end
    if (exp.last !== last) begin
      $error("last: expected %0d, actual %0d", exp.last, last);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  localparam int STORE_DEPTH = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  snap_align_scoreboard sketch_sb = new();

  int unsigned rx_mode = 0;
  int unsigned tx_gap_max = 0;
  int unsigned burst_left = 0;
  bit          rx_hold_req = 1'b0;

  sketch_point_snap_align #(.MAX_POINTS(STORE_DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("[sketch_point_snap_align] ERROR");
    $finish;
  end

  // The receiver runs its own stall pattern; a hold-off request keeps it stalled for a long
  // stretch so the block backs up into its input.
  initial begin
    int unsigned tick;
    tick = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ((tick % 7) < 3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sketch_sb.check_beat(m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[9:5], m_axis_tlast);
    end
  end

  task automatic send_item(input logic op, input logic [23:0] x, input logic [23:0] y);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sketch_sb.note_item(op, x, y);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sketch_sb.expected_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sketch_sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [22:0] r, input logic snap, input logic h,
                           input logic v, input int unsigned rx, input int unsigned gap_max);
    drain();
    repeat (8) @(posedge clk_i);
    write_reg(REG_SNAP_RADIUS, {9'd0, r});
    write_reg(REG_SNAP_EN, {31'd0, snap});
    write_reg(REG_HORIZ_EN, {31'd0, h});
    write_reg(REG_VERT_EN, {31'd0, v});
    rx_mode    = rx;
    tx_gap_max = gap_max;
  endtask

  function automatic logic [23:0] nudge(logic signed [23:0] base, int unsigned span);
    longint offset;
    offset = longint'($urandom_range(0, 2 * span)) - longint'(span);
    return 24'(longint'(base) + offset);
  endfunction

  function automatic logic [23:0] extreme_coord();
    case ($urandom_range(0, 3))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return 24'h000000;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  // Most adds land near a stored point, on its row or on its column, so that snapping and
  // alignment are reached often; the rest are clears, free points and extremes.
  task automatic run_random(input int n);
    logic        op;
    logic [23:0] x, y;
    int unsigned sel, j, span, r;
    for (int k = 0; k < n; k++) begin
      op   = OP_ADD;
      x    = 24'($urandom);
      y    = 24'($urandom);
      sel  = $urandom_range(0, 11);
      r    = sketch_sb.radius;
      span = r + r / 2 + 1;
      j    = (sketch_sb.count == 0) ? 0 : $urandom_range(0, sketch_sb.count - 1);
      if (sel == 0) begin
        op = OP_CLEAR;
      end else if (sketch_sb.count != 0 && sel <= 4) begin
        x = nudge(sketch_sb.px[j], span);
        y = nudge(sketch_sb.py[j], span);
      end else if (sketch_sb.count != 0 && sel <= 6) begin
        y = nudge(sketch_sb.py[j], r);
      end else if (sketch_sb.count != 0 && sel <= 8) begin
        x = nudge(sketch_sb.px[j], r);
      end else if (sel == 9) begin
        x = extreme_coord();
        y = extreme_coord();
      end
      send_item(op, x, y);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rx_mode    = 1;
    tx_gap_max = 3;
    send_item(OP_ADD, 24'd0, 24'd0);
    send_item(OP_ADD, 24'd0, 24'd0);
    send_item(OP_ADD, 24'h7FFFFF, 24'd0);
    send_item(OP_ADD, 24'd0, 24'h7FFFFF);
    send_item(OP_ADD, 24'h800000, 24'h800000);
    send_item(OP_CLEAR, 24'hFFFFFF, 24'hFFFFFF);
    // A full row of points: every pair is horizontally aligned.
    for (int i = 0; i < STORE_DEPTH; i++) begin
      send_item(OP_ADD, 24'(i * 8192 - 65536), 24'd0);
    end
    send_item(OP_ADD, 24'(STORE_DEPTH * 8192 - 65536), 24'd0);
    send_item(OP_ADD, 24'(3 * 8192 - 65536 + 100), 24'd50);
    send_item(OP_CLEAR, 24'd0, 24'd0);

    configure(23'd4096, 1'b1, 1'b1, 1'b1, 0, 0);
    run_random(30);
    rx_hold_req = 1'b1;
    run_random(50);

    configure(23'd0, 1'b1, 1'b1, 1'b1, 2, 4);
    run_random(30);

    configure(23'h7FFFFF, 1'b0, 1'b1, 1'b1, 3, 2);
    run_random(40);

    configure(23'd1, 1'b1, 1'b1, 1'b1, 1, 0);
    run_random(30);

    configure(23'd20000, 1'b1, 1'b0, 1'b1, 0, 6);
    run_random(20);
    drain();
    run_random(20);

    configure(23'd20000, 1'b1, 1'b1, 1'b0, 2, 1);
    run_random(40);

    configure(23'd50000, 1'b1, 1'b0, 1'b0, 3, 3);
    run_random(30);

    for (int p = 0; p < 3; p++) begin
      configure(23'($urandom_range(1, 1 << 20)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), p + 1, 2 * p);
      run_random(25);
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (sketch_sb.mismatches == 0) begin
      $display("[sketch_point_snap_align] OK");
    end else begin
      $display("[sketch_point_snap_align] ERROR");
    end
    $finish;
  end
endmodule

// ===== sketch_point_snap_align.f =====
rtl/spsa_pkg.sv
rtl/spsa_ctrl.sv
rtl/spsa_dp.sv
rtl/sketch_point_snap_align.sv
bench/testbench.sv
